// ===== rtl/dmh_pkg.sv =====
`default_nettype none
package dmh_pkg;
  localparam int Capacity = 128;
  localparam int AddrW = $clog2(Capacity);
  localparam int CntW = $clog2(Capacity + 1);
  localparam int SumW = 39;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] deadline;
    logic [31:0] cost;
  } slot_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    REQ_PUSH = 1'b0,
    REQ_POP  = 1'b1
  } req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_POP_RD,
    S_POP_WR,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMP,
    S_ROOT_RD,
    S_ROOT_WAIT,
    S_OUT
  } state_t;
endpackage
`default_nettype wire

// ===== rtl/dmh_if.sv =====
`default_nettype none
interface dmh_in_if;
  logic        valid;
  logic        ready;
  logic [0:0]  req_type;
  logic [31:0] task_id;
  logic [31:0] task_deadline;
  logic [31:0] task_cost;
  modport source (output valid, req_type, task_id, task_deadline, task_cost, input ready);
  modport sink (input valid, req_type, task_id, task_deadline, task_cost, output ready);
endinterface

interface dmh_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] popped_id;
  logic [31:0] popped_deadline;
  logic [31:0] popped_cost;
  logic [31:0] next_deadline;
  logic [7:0]  pending_count;
  logic [38:0] queued_cost;
  modport source (output valid, status, popped_id, popped_deadline, popped_cost,
                  next_deadline, pending_count, queued_cost, input ready);
  modport sink (input valid, status, popped_id, popped_deadline, popped_cost,
                next_deadline, pending_count, queued_cost, output ready);
endinterface
`default_nettype wire

// ===== rtl/dmh_ram.sv =====
`default_nettype none
module dmh_ram #(
  parameter int Depth = 128,
  parameter int Width = 96
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/deadline_min_heap_scheduler.sv =====
`default_nettype none
// Earliest-deadline-first task queue held as a binary min-heap in one
// single-port-write, one-read synchronous RAM of dmh_pkg::Capacity entries.
// A push appends the task and sifts it up, stopping on an equal deadline; a
// pop returns the root, moves the last entry to the root and sifts it down,
// taking the left child on a tie. One request is worked at a time, paced by
// the single RAM read port, and a refused push or a pop on an empty heap
// skips the sift. A result still waiting on the output register holds the
// next one back.
// Every beat reports next deadline (all ones when empty), pending count and
// total cost. No clearing pass: only live entries are ever used.
module deadline_min_heap_scheduler (
  input wire logic clk,
  input wire logic rst_n,
  dmh_in_if.sink   in_ch,
  dmh_out_if.source out_ch
);
  localparam int AW = dmh_pkg::AddrW;
  localparam int CW = dmh_pkg::CntW;

  dmh_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] count_r;
  logic [dmh_pkg::SumW-1:0] sum_r;
  logic [AW-1:0] pos_r;          // hole the sifted entry sits over
  dmh_pkg::slot_t cur_r;         // entry being sifted
  dmh_pkg::slot_t lch_r;         // left child of the hole
  dmh_pkg::slot_t pop_r;         // removed root, zero unless a pop succeeds
  logic place_r;                 // cur_r still has to land at pos_r
  dmh_pkg::status_t stat_r;

  // RAM port
  logic we;
  logic [AW-1:0] waddr, raddr;
  dmh_pkg::slot_t wdata, rdata;

  dmh_ram #(.Depth(dmh_pkg::Capacity), .Width($bits(dmh_pkg::slot_t))) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic accept;
  assign in_ch.ready = (state_r == dmh_pkg::S_IDLE);
  assign accept = in_ch.valid && in_ch.ready;

  logic [AW-1:0] parent;
  assign parent = (pos_r - AW'(1)) >> 1;
  logic [CW:0] lidx, ridx, cnt_x;
  assign lidx = (CW+1)'({pos_r, 1'b1});
  assign ridx = lidx + (CW+1)'(1);
  assign cnt_x = (CW+1)'(count_r);

  logic has_l, has_r;
  assign has_l = lidx < cnt_x;
  assign has_r = ridx < cnt_x;

  // Sift-up moves on a strictly earlier deadline than the parent's.
  logic up_move;
  assign up_move = cur_r.deadline < rdata.deadline;

  // Sift-down: left child first, right child only when strictly better.
  logic l_wins, r_wins, dn_move;
  assign l_wins = lch_r.deadline < cur_r.deadline;
  assign r_wins = has_r &&
                  (rdata.deadline < (l_wins ? lch_r.deadline : cur_r.deadline));
  assign dn_move = l_wins || r_wins;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dmh_pkg::S_IDLE: begin
        if (accept) begin
          if (in_ch.req_type == dmh_pkg::REQ_PUSH) begin
            if (count_r >= CW'(dmh_pkg::Capacity)) state_nxt = dmh_pkg::S_ROOT_RD;
            else if (count_r == '0) state_nxt = dmh_pkg::S_ROOT_RD;
            else state_nxt = dmh_pkg::S_UP_RD;
          end else begin
            if (count_r == '0) state_nxt = dmh_pkg::S_ROOT_RD;
            else state_nxt = dmh_pkg::S_POP_RD;
          end
        end
      end
      dmh_pkg::S_UP_RD: state_nxt = dmh_pkg::S_UP_CMP;
      dmh_pkg::S_UP_CMP: begin
        if (up_move && parent != '0) state_nxt = dmh_pkg::S_UP_RD;
        else state_nxt = dmh_pkg::S_ROOT_RD;
      end
      dmh_pkg::S_POP_RD: state_nxt = dmh_pkg::S_POP_WR;
      dmh_pkg::S_POP_WR: begin
        if (count_r == '0) state_nxt = dmh_pkg::S_ROOT_RD;
        else state_nxt = dmh_pkg::S_DN_RDL;
      end
      dmh_pkg::S_DN_RDL: begin
        if (has_l) state_nxt = dmh_pkg::S_DN_RDR;
        else state_nxt = dmh_pkg::S_ROOT_RD;
      end
      dmh_pkg::S_DN_RDR: state_nxt = dmh_pkg::S_DN_CMP;
      dmh_pkg::S_DN_CMP: begin
        if (dn_move) state_nxt = dmh_pkg::S_DN_RDL;
        else state_nxt = dmh_pkg::S_ROOT_RD;
      end
      dmh_pkg::S_ROOT_RD: state_nxt = dmh_pkg::S_ROOT_WAIT;
      dmh_pkg::S_ROOT_WAIT: state_nxt = dmh_pkg::S_OUT;
      dmh_pkg::S_OUT: if (!out_ch.valid || out_ch.ready) state_nxt = dmh_pkg::S_IDLE;
      default: state_nxt = dmh_pkg::S_IDLE;
    endcase
  end

  // RAM access: reads default to the root, writes fill the hole
  always_comb begin
    we = 1'b0;
    waddr = pos_r;
    wdata = cur_r;
    raddr = '0;
    case (state_r)
      dmh_pkg::S_UP_RD: raddr = parent;
      dmh_pkg::S_UP_CMP: begin
        // parent drops into the hole
        if (up_move) begin
          we = 1'b1;
          wdata = rdata;
        end
      end
      dmh_pkg::S_POP_RD: raddr = AW'(count_r - CW'(1));
      dmh_pkg::S_DN_RDL: raddr = AW'(lidx);
      dmh_pkg::S_DN_RDR: raddr = AW'(ridx);
      dmh_pkg::S_DN_CMP: begin
        // winning child rises into the hole
        if (dn_move) begin
          we = 1'b1;
          wdata = r_wins ? rdata : lch_r;
        end
      end
      dmh_pkg::S_ROOT_RD: begin
        // settle the sifted entry; the root is read back in S_ROOT_WAIT
        we = place_r;
      end
      default: ;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dmh_pkg::S_IDLE;
      count_r <= '0;
      sum_r <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        dmh_pkg::S_IDLE: begin
          if (accept) begin
            pop_r <= '0;
            place_r <= 1'b0;
            stat_r <= dmh_pkg::ST_DONE;
            cur_r <= '{in_ch.task_id, in_ch.task_deadline, in_ch.task_cost};
            pos_r <= AW'(count_r);
            if (in_ch.req_type == dmh_pkg::REQ_PUSH) begin
              if (count_r >= CW'(dmh_pkg::Capacity)) begin
                stat_r <= dmh_pkg::ST_FULL;
              end else begin
                place_r <= 1'b1;
                count_r <= count_r + CW'(1);
                sum_r <= sum_r + dmh_pkg::SumW'(in_ch.task_cost);
              end
            end else if (count_r == '0) begin
              stat_r <= dmh_pkg::ST_EMPTY;
            end
          end
        end
        dmh_pkg::S_UP_CMP: begin
          if (up_move) pos_r <= parent;
        end
        dmh_pkg::S_POP_RD: begin
          // rdata holds the root, read while the request was accepted
          pop_r <= rdata;
          sum_r <= sum_r - dmh_pkg::SumW'(rdata.cost);
          count_r <= count_r - CW'(1);
        end
        dmh_pkg::S_POP_WR: begin
          // rdata holds the last entry; it restarts from the root
          cur_r <= rdata;
          pos_r <= '0;
          place_r <= (count_r != '0);
        end
        dmh_pkg::S_DN_RDR: begin
          lch_r <= rdata;
        end
        dmh_pkg::S_DN_CMP: begin
          if (dn_move) pos_r <= r_wins ? AW'(ridx) : AW'(lidx);
        end
        dmh_pkg::S_OUT: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.status <= stat_r;
            out_ch.popped_id <= pop_r.id;
            out_ch.popped_deadline <= pop_r.deadline;
            out_ch.popped_cost <= pop_r.cost;
            out_ch.next_deadline <= (count_r == '0) ? 32'hFFFF_FFFF : rdata.deadline;
            out_ch.pending_count <= 8'(count_r);
            out_ch.queued_cost <= sum_r;
          end
        end
        default: ;
      endcase
      // load a new beat or drop the one just taken
      if (state_r == dmh_pkg::S_OUT && (!out_ch.valid || out_ch.ready)) out_ch.valid <= 1'b1;
      else if (out_ch.ready) out_ch.valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire
